>>> rtl/mhmb_pkg.sv
// ----------------------------------------------------------------------------
// mhmb_pkg: shared definitions for the host/MCU mailbox
// Access codes, field widths and the bit positions of the port C flags.
// ----------------------------------------------------------------------------
`default_nettype none

package mhmb_pkg;

	localparam int unsigned OpW   = 4;
	localparam int unsigned ByteW = 8;

	typedef logic [ByteW-1:0] byte_t;

	typedef enum logic [OpW-1:0] {
		OP_HOST_RD = 4'd0,
		OP_HOST_WR = 4'd1,
		OP_A_RD    = 4'd2,
		OP_A_WR    = 4'd3,
		OP_A_DDR   = 4'd4,
		OP_C_RD    = 4'd5,
		OP_C_WR    = 4'd6,
		OP_C_DDR   = 4'd7,
		OP_STATUS  = 4'd8
	} op_t;

	// Port C strobe bits driven by the MCU.
	localparam int unsigned StrobeTakeBit = 2;
	localparam int unsigned StrobeSendBit = 3;
	// Flag bits shown on port C and in the status byte.
	localparam int unsigned FlagBit0 = 0;
	localparam int unsigned FlagBit1 = 1;

endpackage

`default_nettype wire

>>> rtl/mhmb_core.sv
// ----------------------------------------------------------------------------
// mhmb_core: mailbox state and access decode
// Holds the port latches, direction registers, mailbox bytes and pending
// flags. The read byte is formed combinationally; state updates on fire.
// ----------------------------------------------------------------------------
`default_nettype none

module mhmb_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire mhmb_pkg::op_t   op,
	input  wire mhmb_pkg::byte_t wdata,
	output mhmb_pkg::byte_t      rdata
);

	mhmb_pkg::byte_t a_out_q, a_dir_q, a_in_q, c_out_q, c_dir_q;
	mhmb_pkg::byte_t to_host_q, from_host_q;
	logic            host_pend_q, mcu_pend_q;

	logic take_edge, send_edge;
	mhmb_pkg::byte_t c_flags, status;

	// A strobe fires on a driven bit that goes from 1 to 0.
	assign take_edge = c_dir_q[mhmb_pkg::StrobeTakeBit] & c_out_q[mhmb_pkg::StrobeTakeBit]
		& ~wdata[mhmb_pkg::StrobeTakeBit];
	assign send_edge = c_dir_q[mhmb_pkg::StrobeSendBit] & c_out_q[mhmb_pkg::StrobeSendBit]
		& ~wdata[mhmb_pkg::StrobeSendBit];

	always_comb begin
		c_flags = '0;
		c_flags[mhmb_pkg::FlagBit0] = host_pend_q;
		c_flags[mhmb_pkg::FlagBit1] = ~mcu_pend_q;
		status = '0;
		status[mhmb_pkg::FlagBit0] = ~host_pend_q;
		status[mhmb_pkg::FlagBit1] = ~mcu_pend_q;
	end

	always_comb begin
		unique case (op)
			mhmb_pkg::OP_HOST_RD: rdata = to_host_q;
			mhmb_pkg::OP_A_RD:    rdata = (a_out_q & a_dir_q) | (a_in_q & ~a_dir_q);
			mhmb_pkg::OP_C_RD:    rdata = (c_out_q & c_dir_q) | (c_flags & ~c_dir_q);
			mhmb_pkg::OP_STATUS:  rdata = status;
			default:              rdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_out_q     <= '0;
			a_dir_q     <= '0;
			a_in_q      <= '0;
			c_out_q     <= '0;
			c_dir_q     <= '0;
			to_host_q   <= '0;
			from_host_q <= '0;
			host_pend_q <= 1'b0;
			mcu_pend_q  <= 1'b0;
		end else if (fire) begin
			unique case (op)
				mhmb_pkg::OP_HOST_RD: mcu_pend_q <= 1'b0;
				mhmb_pkg::OP_HOST_WR: begin
					from_host_q <= wdata;
					host_pend_q <= 1'b1;
				end
				mhmb_pkg::OP_A_WR:  a_out_q <= wdata;
				mhmb_pkg::OP_A_DDR: a_dir_q <= wdata;
				mhmb_pkg::OP_C_WR: begin
					if (take_edge) begin
						host_pend_q <= 1'b0;
						a_in_q      <= from_host_q;
					end
					if (send_edge) begin
						mcu_pend_q <= 1'b1;
						to_host_q  <= a_out_q;
					end
					c_out_q <= wdata;
				end
				mhmb_pkg::OP_C_DDR: c_dir_q <= wdata;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/mcu_host_mailbox_ports.sv
// ----------------------------------------------------------------------------
// mcu_host_mailbox_ports: two-way byte mailbox between a host and an MCU
// Each access word yields one read word; writes return zero.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata bits                           | notes
//  s_axis   | in  | [3:0] op, [11:4] wdata, [15:12] zero | one access per word
//  m_axis   | out | [7:0] rdata                          | one word per access
//
//  An accepted word is held in an input register; when it fires, it is decoded
//  and applied to the mailbox state as its read word lands in the output
//  register, and one word per cycle is sustained while m_tready stays high.
//  The input register drains whenever the output register is empty or taken.
//  arst_n clears all mailbox state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mcu_host_mailbox_ports (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [3:0] op, [11:4] wdata, [15:12] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata   // [7:0] rdata
);

	logic            valid_s1;
	mhmb_pkg::op_t   op_s1;
	mhmb_pkg::byte_t wdata_s1;
	mhmb_pkg::byte_t rdata;
	logic            advance, fire;

	assign advance  = !m_tvalid || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= mhmb_pkg::op_t'(s_tdata[3:0]);
			wdata_s1 <= s_tdata[11:4];
		end
	end

	mhmb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op_s1),
		.wdata  (wdata_s1),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata <= rdata;
		end
	end

endmodule

`default_nettype wire

>>> rtl/mhmb_chk.sv
// ----------------------------------------------------------------------------
// mhmb_chk: port-level checks for the mailbox
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mhmb_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata
);

	// A stalled result word stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result word changed while stalled");

	// With the output register empty the input side can always take a word.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// Every accepted access must be followed by a valid result word.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("accepted access produced no result word");

endmodule

bind mcu_host_mailbox_ports mhmb_chk u_mhmb_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the host/MCU mailbox
// Sends access words on the slave stream and checks every read word on the
// master stream against a local model of the mailbox or a typed-in answer.
// A short table of directed accesses comes first. Random handoff sequences
// and stray accesses follow. Both streams idle at random, and the bench also
// holds the receiver off for a long stretch and lets the sender drain twice.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ClkHalf       = 6;
	localparam int NumRandom     = 1600;
	localparam int IdlePct       = 7;
	localparam int HoldAtCycle   = 400;
	localparam int HoldCycles    = 64;
	localparam int RxQuietLo     = 1500;
	localparam int RxQuietHi     = 2100;
	localparam int TailCycles    = 8;
	localparam int TimeoutCycles = 100000;

	typedef logic [mhmb_pkg::OpW-1:0] opc_t;

	// Access codes that the block treats as no-ops.
	localparam opc_t OP_UNUSED_LO = 4'd9;
	localparam opc_t OP_UNUSED_HI = 4'd15;

	typedef struct packed {
		opc_t            op;
		mhmb_pkg::byte_t wdata;
		logic            known;  // rdata below is the typed-in answer
		mhmb_pkg::byte_t rdata;
	} dir_row_t;

	typedef struct {
		opc_t            op;
		mhmb_pkg::byte_t wdata;
		logic            known;
		mhmb_pkg::byte_t rdata;
		logic            drain;  // wait for all read words before offering
	} access_t;

	localparam int NumDir = 24;
	localparam dir_row_t DirRows [NumDir] = '{
		'{mhmb_pkg::OP_STATUS,  8'h00, 1'b1, 8'h03},
		'{mhmb_pkg::OP_C_RD,    8'hFF, 1'b1, 8'h02},
		'{mhmb_pkg::OP_A_RD,    8'hFF, 1'b1, 8'h00},
		'{mhmb_pkg::OP_HOST_RD, 8'h00, 1'b1, 8'h00},
		'{mhmb_pkg::OP_HOST_WR, 8'hFF, 1'b1, 8'h00},
		'{mhmb_pkg::OP_STATUS,  8'h00, 1'b1, 8'h02},
		'{mhmb_pkg::OP_HOST_WR, 8'hA5, 1'b1, 8'h00},
		'{mhmb_pkg::OP_C_DDR,   8'hFF, 1'b1, 8'h00},
		'{mhmb_pkg::OP_C_WR,    8'hFF, 1'b1, 8'h00},
		'{mhmb_pkg::OP_A_WR,    8'h3C, 1'b1, 8'h00},
		'{mhmb_pkg::OP_C_WR,    8'h00, 1'b1, 8'h00},
		'{mhmb_pkg::OP_C_RD,    8'h00, 1'b0, 8'h00},
		'{mhmb_pkg::OP_A_DDR,   8'h00, 1'b1, 8'h00},
		'{mhmb_pkg::OP_A_RD,    8'h00, 1'b0, 8'h00},
		'{mhmb_pkg::OP_STATUS,  8'hFF, 1'b0, 8'h00},
		'{mhmb_pkg::OP_HOST_RD, 8'hFF, 1'b0, 8'h00},
		'{mhmb_pkg::OP_C_DDR,   8'h00, 1'b1, 8'h00},
		'{mhmb_pkg::OP_C_RD,    8'h00, 1'b0, 8'h00},
		'{mhmb_pkg::OP_A_DDR,   8'hFF, 1'b1, 8'h00},
		'{mhmb_pkg::OP_A_RD,    8'h00, 1'b0, 8'h00},
		'{OP_UNUSED_LO,         8'hFF, 1'b1, 8'h00},
		'{OP_UNUSED_HI,         8'hFF, 1'b1, 8'h00},
		'{mhmb_pkg::OP_C_DDR,   8'hF3, 1'b1, 8'h00},
		'{mhmb_pkg::OP_C_WR,    8'h00, 1'b1, 8'h00}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [3:0] op, [11:4] wdata, [15:12] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] rdata

	// Local copy of the mailbox state.
	mhmb_pkg::byte_t a_out, a_dir, a_in, c_out, c_dir, to_host, from_host;
	logic            host_pend, mcu_pend;

	access_t         access_q [$];
	mhmb_pkg::byte_t rdata_q [$];
	int              acc_idx;
	int              errors;
	mhmb_pkg::byte_t want_rd;
	mhmb_pkg::byte_t model_rd;

	mcu_host_mailbox_ports u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #ClkHalf clk = ~clk;

	// Applies one access to the local state and returns its read word.
	function automatic mhmb_pkg::byte_t mailbox_apply(opc_t op, mhmb_pkg::byte_t wd);
		mhmb_pkg::byte_t rd;
		mhmb_pkg::byte_t flags;
		logic            take;
		logic            send;
		rd    = '0;
		flags = '0;
		case (op)
			mhmb_pkg::OP_HOST_RD: begin
				rd       = to_host;
				mcu_pend = 1'b0;
			end
			mhmb_pkg::OP_HOST_WR: begin
				from_host = wd;
				host_pend = 1'b1;
			end
			mhmb_pkg::OP_A_RD:  rd = (a_out & a_dir) | (a_in & ~a_dir);
			mhmb_pkg::OP_A_WR:  a_out = wd;
			mhmb_pkg::OP_A_DDR: a_dir = wd;
			mhmb_pkg::OP_C_RD: begin
				flags[mhmb_pkg::FlagBit0] = host_pend;
				flags[mhmb_pkg::FlagBit1] = ~mcu_pend;
				rd = (c_out & c_dir) | (flags & ~c_dir);
			end
			mhmb_pkg::OP_C_WR: begin
				// Both strobes look at the old latch before it is replaced.
				take = c_dir[mhmb_pkg::StrobeTakeBit] & c_out[mhmb_pkg::StrobeTakeBit]
					& ~wd[mhmb_pkg::StrobeTakeBit];
				send = c_dir[mhmb_pkg::StrobeSendBit] & c_out[mhmb_pkg::StrobeSendBit]
					& ~wd[mhmb_pkg::StrobeSendBit];
				if (take) begin
					host_pend = 1'b0;
					a_in      = from_host;
				end
				if (send) begin
					mcu_pend = 1'b1;
					to_host  = a_out;
				end
				c_out = wd;
			end
			mhmb_pkg::OP_C_DDR: c_dir = wd;
			mhmb_pkg::OP_STATUS: begin
				rd[mhmb_pkg::FlagBit0] = ~host_pend;
				rd[mhmb_pkg::FlagBit1] = ~mcu_pend;
			end
			default: ;
		endcase
		return rd;
	endfunction

	task automatic add_access(opc_t op, mhmb_pkg::byte_t wd);
		access_t a;
		a.op    = op;
		a.wdata = wd;
		a.known = 1'b0;
		a.rdata = '0;
		a.drain = 1'b0;
		access_q.push_back(a);
	endtask

	// A host-to-MCU and MCU-to-host handoff with random content.
	task automatic add_handoff();
		mhmb_pkg::byte_t low_mask;
		case ($urandom_range(0, 2))
			0:       low_mask = 8'h04;
			1:       low_mask = 8'h08;
			default: low_mask = 8'h0C;
		endcase
		if ($urandom_range(0, 3) == 0)
			add_access(mhmb_pkg::OP_C_DDR, mhmb_pkg::byte_t'($urandom)
				| ($urandom_range(0, 4) != 0 ? 8'h0C : 8'h00));
		if ($urandom_range(0, 2) == 0)
			add_access(mhmb_pkg::OP_A_DDR, mhmb_pkg::byte_t'($urandom));
		add_access(mhmb_pkg::OP_HOST_WR, mhmb_pkg::byte_t'($urandom));
		if ($urandom_range(0, 4) == 0)
			add_access(mhmb_pkg::OP_HOST_WR, mhmb_pkg::byte_t'($urandom));
		add_access(mhmb_pkg::OP_A_WR, mhmb_pkg::byte_t'($urandom));
		add_access(mhmb_pkg::OP_C_WR, mhmb_pkg::byte_t'($urandom) | 8'h0C);
		add_access($urandom_range(0, 1) ? mhmb_pkg::OP_C_RD : mhmb_pkg::OP_STATUS,
			mhmb_pkg::byte_t'($urandom));
		add_access(mhmb_pkg::OP_C_WR, mhmb_pkg::byte_t'($urandom) & ~low_mask);
		add_access(mhmb_pkg::OP_A_RD, mhmb_pkg::byte_t'($urandom));
		add_access(mhmb_pkg::OP_STATUS, mhmb_pkg::byte_t'($urandom));
		add_access(mhmb_pkg::OP_HOST_RD, mhmb_pkg::byte_t'($urandom));
		add_access(mhmb_pkg::OP_C_RD, mhmb_pkg::byte_t'($urandom));
	endtask

	// Checks read words and predicts from accepted access words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (rdata_q.size() == 0) begin
					errors++;
					$display("%0t: rdata expected none actual %02h", $time, m_tdata);
				end else begin
					want_rd = rdata_q.pop_front();
					if (m_tdata !== want_rd) begin
						errors++;
						$display("%0t: rdata expected %02h actual %02h", $time, want_rd, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				model_rd = mailbox_apply(s_tdata[3:0], s_tdata[11:4]);
				rdata_q.push_back(access_q[acc_idx].known ? access_q[acc_idx].rdata : model_rd);
				acc_idx++;
			end
		end
	end

	// Receiver: random stalls, one long hold-off, and a window with no stalls.
	initial begin
		int rx_cycle;
		rx_cycle = 0;
		m_tready = 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (rx_cycle == HoldAtCycle) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				rx_cycle += HoldCycles;
			end else begin
				m_tready <= !(rx_cycle < RxQuietLo || rx_cycle >= RxQuietHi) ||
					($urandom_range(0, 99) >= IdlePct);
			end
			@(posedge clk);
			rx_cycle++;
		end
	end

	initial begin
		#(TimeoutCycles * 2 * ClkHalf);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int      quiet_lo;
		int      quiet_hi;
		int      idle;
		access_t a;
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		errors    = 0;
		acc_idx   = 0;
		a_out     = '0;
		a_dir     = '0;
		a_in      = '0;
		c_out     = '0;
		c_dir     = '0;
		to_host   = '0;
		from_host = '0;
		host_pend = 1'b0;
		mcu_pend  = 1'b0;

		foreach (DirRows[i]) begin
			a.op    = DirRows[i].op;
			a.wdata = DirRows[i].wdata;
			a.known = DirRows[i].known;
			a.rdata = DirRows[i].rdata;
			a.drain = 1'b0;
			access_q.push_back(a);
		end
		while (access_q.size() < NumDir + NumRandom) begin
			if ($urandom_range(0, 9) < 7)
				add_handoff();
			else
				repeat ($urandom_range(1, 4))
					add_access(opc_t'($urandom_range(0, 15)), mhmb_pkg::byte_t'($urandom));
		end
		access_q[NumDir].drain = 1'b1;
		access_q[NumDir + NumRandom / 2].drain = 1'b1;
		quiet_lo = NumDir + 300;
		quiet_hi = NumDir + 700;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < access_q.size(); i++) begin
			if (access_q[i].drain) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (rdata_q.size() != 0)
					@(posedge clk);
			end
			idle = (i >= quiet_lo && i < quiet_hi) ? 0 : IdlePct;
			while ($urandom_range(0, 99) < idle) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= {4'h0, access_q[i].wdata, access_q[i].op};
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		while (rdata_q.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/mhmb_pkg.sv
rtl/mhmb_core.sv
rtl/mcu_host_mailbox_ports.sv
rtl/mhmb_chk.sv
tb/sv/tb_top.sv
